### rtl/brl_pkg.sv
`default_nettype none

package brl_pkg;

  // Fixed field widths of the line engine.
  localparam int unsigned CoordBits = 10;
  localparam int unsigned ErrBits   = CoordBits + 2;
  localparam int unsigned RegBits   = 11;
  localparam int unsigned AddrBits  = 20;
  localparam int unsigned ColorBits = 8;

  // Item kinds on the input channel.
  localparam logic KindStart = 1'b0;
  localparam logic KindTick  = 1'b1;

  // Configuration register indexes.
  localparam logic RegClipWidth  = 1'b0;
  localparam logic RegClipHeight = 1'b1;

  localparam logic [RegBits-1:0] ClipWidthReset  = 11'd320;
  localparam logic [RegBits-1:0] ClipHeightReset = 11'd200;

  typedef struct packed {
    logic                 kind;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
    logic [ColorBits-1:0] color;
  } in_item_t;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic [AddrBits-1:0]  pixel_address;
    logic [ColorBits-1:0] pixel_color;
    logic                 visible;
    logic                 last;
  } out_item_t;

  // Classified command handed from the front end to the stepping engine.
  typedef struct packed {
    logic                      kind;
    logic [CoordBits-1:0]      pos_x;
    logic [CoordBits-1:0]      pos_y;
    logic [CoordBits-1:0]      target_x;
    logic [CoordBits-1:0]      target_y;
    logic [CoordBits-1:0]      delta_x;
    logic [CoordBits-1:0]      delta_y;
    logic                      step_x_neg;
    logic                      step_y_neg;
    logic signed [ErrBits-1:0] error_term;
    logic [ColorBits-1:0]      color;
  } cmd_t;

  // Clip settings seen by the engine.
  typedef struct packed {
    logic [RegBits-1:0] clip_width;
    logic [RegBits-1:0] clip_height;
  } clip_cfg_t;

endpackage

`default_nettype wire

### rtl/bresenham_line_rasterizer_core.sv
`default_nettype none

// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid_i / in_stall_o | kind, endpoints, color
// out     | output    | out_valid_o / out_stall_i | point, address, flags
// cfg     | input     | cfg_we_i               | clip width or height
//
// One input beat per cycle while in_stall_o is low; a tick on an active line yields
// its point through a queue entry, then the output register fed by the engine.
// The engine step, one 10x11 multiply plus add for the address, sets the rate.
// Reset clears the queue and the engine and loads clip 320 by 200.
// A stalled output holds its beat and stops the engine; the queue then takes
// beats until all QueueDepth entries are filled before in_stall_o rises.
module bresenham_line_rasterizer_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire brl_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output brl_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [brl_pkg::RegBits-1:0]   cfg_data_i
);
  import brl_pkg::*;

  clip_cfg_t cfg_q, cfg_d;
  logic      q_full;
  logic      q_push;
  logic      q_valid;
  logic      q_pop;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegClipWidth:  cfg_d.clip_width  = cfg_data_i;
        RegClipHeight: cfg_d.clip_height = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_width  <= ClipWidthReset;
      cfg_q.clip_height <= ClipHeightReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: accepts beats and sets up lines.
  brl_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  // Command queue between the two sides.
  brl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd),
    .pop_i      (q_pop)
  );

  // Stepping engine and output register.
  brl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/brl_front.sv
`default_nettype none

module brl_front (
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire brl_pkg::in_item_t in_data_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output brl_pkg::cmd_t         q_cmd_o
);
  import brl_pkg::*;

  logic [CoordBits-1:0] delta_x;
  logic [CoordBits-1:0] delta_y;

  // Accept a beat whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Line setup: absolute deltas, step directions and the initial error term.
  always_comb begin
    delta_x = (in_data_i.start_x > in_data_i.end_x) ? in_data_i.start_x - in_data_i.end_x
                                                    : in_data_i.end_x - in_data_i.start_x;
    delta_y = (in_data_i.start_y > in_data_i.end_y) ? in_data_i.start_y - in_data_i.end_y
                                                    : in_data_i.end_y - in_data_i.start_y;
    q_cmd_o.kind       = in_data_i.kind;
    q_cmd_o.pos_x      = in_data_i.start_x;
    q_cmd_o.pos_y      = in_data_i.start_y;
    q_cmd_o.target_x   = in_data_i.end_x;
    q_cmd_o.target_y   = in_data_i.end_y;
    q_cmd_o.delta_x    = delta_x;
    q_cmd_o.delta_y    = delta_y;
    q_cmd_o.step_x_neg = !(in_data_i.start_x < in_data_i.end_x);
    q_cmd_o.step_y_neg = !(in_data_i.start_y < in_data_i.end_y);
    q_cmd_o.error_term = $signed({2'b00, delta_x}) - $signed({2'b00, delta_y});
    q_cmd_o.color      = in_data_i.color;
  end

endmodule

`default_nettype wire

### rtl/brl_fifo.sv
`default_nettype none

module brl_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire brl_pkg::cmd_t push_cmd_i,
  output logic              full_o,
  output logic              valid_o,
  output brl_pkg::cmd_t     pop_cmd_o,
  input  wire logic         pop_i
);
  import brl_pkg::*;

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  cmd_t               mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o    = (count_q == CntBits'(Depth));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

### rtl/brl_back.sv
`default_nettype none

module brl_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire brl_pkg::clip_cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  input  wire brl_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output brl_pkg::out_item_t out_data_o
);
  import brl_pkg::*;

  logic                      busy_q, busy_d;
  logic [CoordBits-1:0]      pos_x_q, pos_x_d;
  logic [CoordBits-1:0]      pos_y_q, pos_y_d;
  logic [CoordBits-1:0]      target_x_q, target_x_d;
  logic [CoordBits-1:0]      target_y_q, target_y_d;
  logic [CoordBits-1:0]      delta_x_q, delta_x_d;
  logic [CoordBits-1:0]      delta_y_q, delta_y_d;
  logic                      step_x_neg_q, step_x_neg_d;
  logic                      step_y_neg_q, step_y_neg_d;
  logic signed [ErrBits-1:0] error_q, error_d;
  logic [ColorBits-1:0]      color_q, color_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  logic                        out_ready;
  logic                        emit;
  logic                        is_last;
  logic                        step_x;
  logic                        step_y;
  logic signed [ErrBits:0]     e2;
  logic [CoordBits+RegBits-1:0] row_base;

  // The output register takes a new beat when empty or being drained.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign pop_o     = cmd_valid_i && out_ready;
  assign emit      = pop_o && (cmd_i.kind == KindTick) && busy_q;

  // Current point and the error rule for the next one.
  assign is_last  = (pos_x_q == target_x_q) && (pos_y_q == target_y_q);
  assign e2       = {error_q, 1'b0};
  assign step_x   = e2 > -$signed({3'b000, delta_y_q});
  assign step_y   = e2 < $signed({3'b000, delta_x_q});
  assign row_base = pos_y_q * cfg_i.clip_width;

  always_comb begin
    busy_d       = busy_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    target_x_d   = target_x_q;
    target_y_d   = target_y_q;
    delta_x_d    = delta_x_q;
    delta_y_d    = delta_y_q;
    step_x_neg_d = step_x_neg_q;
    step_y_neg_d = step_y_neg_q;
    error_d      = error_q;
    color_d      = color_q;

    if (pop_o && (cmd_i.kind == KindStart)) begin
      busy_d       = 1'b1;
      pos_x_d      = cmd_i.pos_x;
      pos_y_d      = cmd_i.pos_y;
      target_x_d   = cmd_i.target_x;
      target_y_d   = cmd_i.target_y;
      delta_x_d    = cmd_i.delta_x;
      delta_y_d    = cmd_i.delta_y;
      step_x_neg_d = cmd_i.step_x_neg;
      step_y_neg_d = cmd_i.step_y_neg;
      error_d      = cmd_i.error_term;
      color_d      = cmd_i.color;
    end else if (emit) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        error_d = error_q
                  - (step_x ? $signed({2'b00, delta_y_q}) : $signed(ErrBits'(0)))
                  + (step_y ? $signed({2'b00, delta_x_q}) : $signed(ErrBits'(0)));
        if (step_x) begin
          pos_x_d = step_x_neg_q ? pos_x_q - 1'b1 : pos_x_q + 1'b1;
        end
        if (step_y) begin
          pos_y_d = step_y_neg_q ? pos_y_q - 1'b1 : pos_y_q + 1'b1;
        end
      end
    end
  end

  // Output beat for the current point.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_d.pixel_x       = pos_x_q;
      out_d.pixel_y       = pos_y_q;
      out_d.pixel_address = AddrBits'(row_base + {{RegBits{1'b0}}, pos_x_q});
      out_d.pixel_color   = color_q;
      out_d.visible       = ({1'b0, pos_x_q} < cfg_i.clip_width) &&
                            ({1'b0, pos_y_q} < cfg_i.clip_height);
      out_d.last          = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      target_x_q   <= '0;
      target_y_q   <= '0;
      delta_x_q    <= '0;
      delta_y_q    <= '0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      error_q      <= '0;
      color_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      target_x_q   <= target_x_d;
      target_y_q   <= target_y_d;
      delta_x_q    <= delta_x_d;
      delta_y_q    <= delta_y_d;
      step_x_neg_q <= step_x_neg_d;
      step_y_neg_q <= step_y_neg_d;
      error_q      <= error_d;
      color_q      <= color_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stalled output beat blocks the engine from taking commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !pop_o)
    else $error("command taken while output beat is stalled");

  // A tick with no active line produces no beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && (cmd_i.kind == KindTick) && !busy_q |=> !out_valid_q)
    else $error("beat produced by a tick while idle");

  // Emitting the end point retires the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && is_last |=> !busy_q && out_valid_q && out_q.last)
    else $error("end point did not retire the line");

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import brl_pkg::*;

  localparam int CoordMax = (1 << CoordBits) - 1;
  localparam int RegMax = (1 << RegBits) - 1;
  localparam int QuietLimit = 4000;
  localparam int MaxPrinted = 60;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [RegBits-1:0] cfg_data;

  // Shadow of the line walker and of the clip registers.
  logic walk_active;
  logic [CoordBits-1:0] walk_x, walk_y, goal_x, goal_y, span_x, span_y;
  logic x_dec, y_dec;
  logic signed [ErrBits-1:0] walk_err;
  logic [ColorBits-1:0] walk_color;
  logic [RegBits-1:0] clip_w, clip_h;

  out_item_t expected_points[$];

  int error_count = 0;
  int points_checked = 0;
  int lines_started = 0;
  int useful_beats = 0;
  int clip_settings_used = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 8;
  int recv_stall_pct = 53;

  bresenham_line_rasterizer_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("%0t: %s mismatch: got %0d, predicted %0d (point %0d)",
               $time, field, got, want, points_checked);
    end
  endtask

  // Walk the line one beat at a time and queue the point each live tick emits.
  function automatic void rasterize_beat(input in_item_t beat);
    out_item_t pt;
    logic [31:0] offset;
    int doubled_err;
    if (beat.kind == KindStart) begin
      walk_x = beat.start_x;
      walk_y = beat.start_y;
      goal_x = beat.end_x;
      goal_y = beat.end_y;
      walk_color = beat.color;
      span_x = (walk_x > goal_x) ? walk_x - goal_x : goal_x - walk_x;
      span_y = (walk_y > goal_y) ? walk_y - goal_y : goal_y - walk_y;
      x_dec = !(walk_x < goal_x);
      y_dec = !(walk_y < goal_y);
      walk_err = ErrBits'(int'(span_x) - int'(span_y));
      walk_active = 1'b1;
      lines_started++;
    end else if (walk_active) begin
      offset = 32'(walk_y) * 32'(clip_w) + 32'(walk_x);
      pt.pixel_x = walk_x;
      pt.pixel_y = walk_y;
      pt.pixel_address = offset[AddrBits-1:0];
      pt.pixel_color = walk_color;
      pt.visible = (RegBits'(walk_x) < clip_w) && (RegBits'(walk_y) < clip_h);
      pt.last = (walk_x == goal_x) && (walk_y == goal_y);
      expected_points.push_back(pt);
      if (pt.last) begin
        walk_active = 1'b0;
      end else begin
        // Both tests use the error term from before this step.
        doubled_err = 2 * int'(walk_err);
        if (doubled_err > -int'(span_y)) begin
          walk_err = walk_err - ErrBits'(span_y);
          walk_x = x_dec ? walk_x - 1'b1 : walk_x + 1'b1;
        end
        if (doubled_err < int'(span_x)) begin
          walk_err = walk_err + ErrBits'(span_x);
          walk_y = y_dec ? walk_y - 1'b1 : walk_y + 1'b1;
        end
      end
    end
  endfunction

  // Compare every delivered point with the oldest predicted one.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unpredicted point, pixel_x", out_data.pixel_x, 0);
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (out_data.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", out_data.pixel_x, want.pixel_x);
        if (out_data.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", out_data.pixel_y, want.pixel_y);
        if (out_data.pixel_address !== want.pixel_address)
          report_mismatch("pixel_address", out_data.pixel_address, want.pixel_address);
        if (out_data.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", out_data.pixel_color, want.pixel_color);
        if (out_data.visible !== want.visible)
          report_mismatch("visible", out_data.visible, want.visible);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // Give up when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, QuietLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t random_payload();
    in_item_t beat;
    beat.kind = 1'($urandom_range(0, 1));
    beat.start_x = CoordBits'($urandom_range(0, CoordMax));
    beat.start_y = CoordBits'($urandom_range(0, CoordMax));
    beat.end_x = CoordBits'($urandom_range(0, CoordMax));
    beat.end_y = CoordBits'($urandom_range(0, CoordMax));
    beat.color = ColorBits'($urandom_range(0, 255));
    return beat;
  endfunction

  function automatic in_item_t make_tick();
    in_item_t beat;
    beat = random_payload();
    beat.kind = KindTick;
    return beat;
  endfunction

  // A coordinate within reach of base, kept on the screen grid.
  function automatic int nudge_coord(input int base, input int reach);
    int v;
    v = base + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return v;
  endfunction

  // Send one beat; called at a falling edge and returns at one.
  // Valid is left high so a following beat can go out back to back.
  task automatic send_beat(input in_item_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (beat.kind == KindStart || walk_active) useful_beats++;
    rasterize_beat(beat);
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted point has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_clip(input int w, input int h);
    wait_for_drain();
    cfg_we <= 1'b1;
    cfg_index <= RegClipWidth;
    cfg_data <= RegBits'(w);
    @(negedge clk);
    cfg_index <= RegClipHeight;
    cfg_data <= RegBits'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    clip_w = RegBits'(w);
    clip_h = RegBits'(h);
    clip_settings_used++;
  endtask

  // Start a line and tick it through to its end point.
  task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                           input int color);
    in_item_t beat;
    beat = random_payload();
    beat.kind = KindStart;
    beat.start_x = CoordBits'(sx);
    beat.start_y = CoordBits'(sy);
    beat.end_x = CoordBits'(ex);
    beat.end_y = CoordBits'(ey);
    beat.color = ColorBits'(color);
    send_beat(beat);
    while (walk_active) send_beat(make_tick());
  endtask

  // Start a line and tick only its first points, leaving the rest undrawn.
  task automatic draw_line_head(input int sx, input int sy, input int ex, input int ey,
                                input int n_ticks);
    in_item_t beat;
    beat = random_payload();
    beat.kind = KindStart;
    beat.start_x = CoordBits'(sx);
    beat.start_y = CoordBits'(sy);
    beat.end_x = CoordBits'(ex);
    beat.end_y = CoordBits'(ey);
    send_beat(beat);
    repeat (n_ticks) send_beat(make_tick());
  endtask

  task automatic test_tick_while_idle();
    send_beat(make_tick());
    wait_for_drain();
  endtask

  // A line whose endpoints coincide is a single point flagged last.
  task automatic test_single_point_line();
    draw_line(5, 7, 5, 7, 8'h5a);
    draw_line(CoordMax, CoordMax, CoordMax, CoordMax, 255);
  endtask

  // Shallow line stepping up, a tick past its end, then a steep line stepping down.
  task automatic test_both_directions();
    draw_line(0, 0, 3, 1, 0);
    send_beat(make_tick());
    draw_line(CoordMax, CoordMax, CoordMax - 2, CoordMax - 3, 255);
  endtask

  // A new start drops the line in progress.
  task automatic test_restart_mid_line();
    in_item_t beat;
    beat = random_payload();
    beat.kind = KindStart;
    beat.start_x = 10;
    beat.start_y = 10;
    beat.end_x = 20;
    beat.end_y = 2;
    send_beat(beat);
    send_beat(make_tick());
    send_beat(make_tick());
    draw_line(100, 300, 99, 301, 8'h3c);
    wait_for_drain();
  endtask

  // Smallest, largest, zero and over-wide clip sizes, with lines at both corners.
  task automatic test_clip_extremes();
    int w_set[6] = '{1, 1024, 0, RegMax, 1024, 1};
    int h_set[6] = '{1, 1024, 0, RegMax, 1, 1024};
    int sx, sy;
    for (int i = 0; i < 6; i++) begin
      set_clip(w_set[i], h_set[i]);
      draw_line(0, 0, 2, 1, $urandom_range(0, 255));
      draw_line(CoordMax, CoordMax, CoordMax - 1, CoordMax - 2, $urandom_range(0, 255));
      sx = $urandom_range(0, CoordMax);
      sy = $urandom_range(0, CoordMax);
      draw_line(sx, sy, nudge_coord(sx, 4), nudge_coord(sy, 4), $urandom_range(0, 255));
    end
    set_clip(ClipWidthReset, ClipHeightReset);
  endtask

  // Mostly complete short lines, some cut short, some stray beats.
  task automatic test_random_traffic(input int n_beats);
    in_item_t beat;
    int target, pick, reach, sx, sy;
    target = useful_beats + n_beats;
    while (useful_beats < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        if ($urandom_range(0, 3) == 0) begin
          set_clip($urandom_range(0, RegMax), $urandom_range(0, RegMax));
        end else begin
          set_clip($urandom_range(1, 1024), $urandom_range(1, 1024));
        end
      end else if (pick < 78) begin
        reach = ($urandom_range(0, 9) == 0) ? 120 : 10;
        sx = $urandom_range(0, CoordMax);
        sy = $urandom_range(0, CoordMax);
        draw_line(sx, sy, nudge_coord(sx, reach), nudge_coord(sy, reach),
                  $urandom_range(0, 255));
        if ($urandom_range(0, 4) == 0) send_beat(make_tick());
      end else if (pick < 90) begin
        beat = random_payload();
        beat.kind = KindStart;
        beat.end_x = CoordBits'(nudge_coord(beat.start_x, 40));
        beat.end_y = CoordBits'(nudge_coord(beat.start_y, 40));
        send_beat(beat);
        repeat ($urandom_range(0, 6)) begin
          if (walk_active) send_beat(make_tick());
        end
      end else if (pick < 94) begin
        wait_for_drain();
      end else begin
        send_beat(random_payload());
      end
    end
  endtask

  // Full-span lines with the widest deltas and error terms, each left after its
  // first points; the first two are dropped by the next start.
  task automatic test_longest_line();
    draw_line_head(0, CoordMax, CoordMax, 0, 40);
    draw_line_head(CoordMax, 0, 0, 1, 40);
    draw_line_head(0, 0, 1, CoordMax, 20);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegClipWidth;
    cfg_data = '0;
    walk_active = 1'b0;
    walk_x = '0;
    walk_y = '0;
    goal_x = '0;
    goal_y = '0;
    span_x = '0;
    span_y = '0;
    x_dec = 1'b0;
    y_dec = 1'b0;
    walk_err = '0;
    walk_color = '0;
    clip_w = ClipWidthReset;
    clip_h = ClipHeightReset;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Sender mostly busy, receiver stalling often.
    test_tick_while_idle();
    test_single_point_line();
    test_both_directions();
    test_restart_mid_line();
    test_clip_extremes();
    test_random_traffic(160);

    // Sender gapping often, receiver mostly ready.
    send_idle_pct = 53;
    recv_stall_pct = 8;
    test_random_traffic(160);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(160);
    test_longest_line();
    wait_for_drain();

    $display("Drew %0d lines, checked %0d points under %0d clip settings,",
             lines_started, points_checked, clip_settings_used);
    $display("with sender gaps and output stalls in both mixes and at full rate.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
rtl/brl_pkg.sv
rtl/brl_front.sv
rtl/brl_fifo.sv
rtl/brl_back.sv
rtl/bresenham_line_rasterizer_core.sv
dv/testbench.sv
